### hw/rtl/ptfa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ptfa_pkg;

	// table geometry
	localparam int PAGE_COUNT  = 256;
	localparam int FRAME_COUNT = 256;
	localparam int PAGE_BYTES  = 4096;

	// fixed field widths
	localparam int ADDR_W   = 20;
	localparam int ACT_W    = 2;
	localparam int STATUS_W = 3;
	localparam int PIDX_W   = 8;

	localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
	localparam int PAGE_W     = $clog2(PAGE_COUNT);
	localparam int FRAME_W    = $clog2(FRAME_COUNT);
	localparam int VPAGE_W    = ADDR_W - PAGE_SHIFT;

	// free-frame scan: one chunk of the in-use bitmap per cycle
	localparam int CHUNK_W  = (FRAME_COUNT < 32) ? FRAME_COUNT : 32;
	localparam int N_CHUNKS = FRAME_COUNT / CHUNK_W;
	localparam int OFF_W    = $clog2(CHUNK_W);
	localparam int CIDX_W   = FRAME_W - OFF_W;
	localparam int STEP_W   = $clog2(N_CHUNKS + 1);

	// command queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// request codes
	localparam logic [ACT_W-1:0] ACT_MAP        = 2'd0;
	localparam logic [ACT_W-1:0] ACT_UNMAP_ADDR = 2'd1;
	localparam logic [ACT_W-1:0] ACT_UNMAP_IDX  = 2'd2;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_MAPPED   = 3'd0;
	localparam logic [STATUS_W-1:0] ST_UNMAPPED = 3'd1;
	localparam logic [STATUS_W-1:0] ST_GUARD    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_OOM      = 3'd3;
	localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd4;

	// classified command kinds
	typedef enum logic [1:0] {
		K_MAP,
		K_UNMAP,
		K_GUARD,
		K_RANGE
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [PAGE_W-1:0] page;
	} cmd_t;

endpackage

`default_nettype wire

### hw/rtl/ptfa_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module ptfa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### hw/rtl/ptfa_front.sv
`timescale 1ns / 1ps
`default_nettype none

module ptfa_front import ptfa_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [ACT_W-1:0]    action,
	input  wire logic [ADDR_W-1:0]   vaddr,
	input  wire logic [PIDX_W-1:0]   page_index,
	output cmd_t                     cmd_s1,
	output logic                     cmd_valid_s1,
	input  wire logic                cmd_ready
);

	logic [VPAGE_W-1:0] vpage;
	cmd_t               cmd;

	assign vpage = vaddr[ADDR_W-1:PAGE_SHIFT];

	always_comb begin
		cmd.kind = K_RANGE;
		cmd.page = '0;
		unique case (action)
			ACT_MAP: begin
				if (32'(vpage) < 32'(PAGE_COUNT)) begin
					cmd.page = PAGE_W'(vpage);
					cmd.kind = (cmd.page == '0) ? K_GUARD : K_MAP;
				end
			end
			ACT_UNMAP_ADDR: begin
				if (32'(vpage) < 32'(PAGE_COUNT)) begin
					cmd.page = PAGE_W'(vpage);
					cmd.kind = K_UNMAP;
				end
			end
			ACT_UNMAP_IDX: begin
				if (32'(page_index) < 32'(PAGE_COUNT)) begin
					cmd.page = PAGE_W'(page_index);
					cmd.kind = K_UNMAP;
				end
			end
			default: begin
				cmd.kind = K_RANGE;
			end
		endcase
	end

	assign in_ready = !cmd_valid_s1 || cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_s1 <= 1'b0;
			cmd_s1       <= '0;
		end else if (in_ready) begin
			cmd_valid_s1 <= in_valid;
			if (in_valid) begin
				cmd_s1 <= cmd;
			end
		end
	end

endmodule

`default_nettype wire

### hw/rtl/ptfa_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module ptfa_queue import ptfa_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cmd_t wr_cmd,
	input  wire logic wr_valid,
	output logic      wr_ready,
	output cmd_t      rd_cmd,
	output logic      rd_valid,
	input  wire logic rd_ready
);

	cmd_t              entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	logic              pop;

	assign wr_ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_cmd   = entries_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= wr_cmd;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/ptfa_back.sv
`timescale 1ns / 1ps
`default_nettype none

module ptfa_back import ptfa_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire cmd_t                 cmd,
	input  wire logic                 cmd_valid,
	output logic                      cmd_ready,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [STATUS_W-1:0]       status,
	output logic [ADDR_W-1:0]         frame_addr,
	output logic [ADDR_W-1:0]         log_vaddr
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_READ   = 2'd1;
	localparam logic [1:0] S_SEARCH = 2'd2;

	logic [1:0]             state_q;
	logic [FRAME_COUNT-1:0] in_use_q;
	logic [PAGE_COUNT-1:0]  pvalid_q;
	logic [FRAME_W-1:0]     next_q;
	kind_t                  kind_q;
	logic [PAGE_W-1:0]      page_q;
	logic                   old_valid_q;
	logic [FRAME_W-1:0]     old_frame_q;
	logic [CIDX_W-1:0]      cidx_q;
	logic [OFF_W-1:0]       start_lo_q;
	logic [STEP_W-1:0]      step_q;
	logic                   out_valid_q;
	logic [STATUS_W-1:0]    status_q;
	logic [ADDR_W-1:0]      frame_addr_q;
	logic [ADDR_W-1:0]      log_q;

	logic                   pop;
	logic [FRAME_W-1:0]     start;
	logic [FRAME_COUNT-1:0] free_vec;
	logic [CHUNK_W-1:0]     chunk;
	logic [CHUNK_W-1:0]     chunk_m;
	logic [OFF_W-1:0]       off;
	logic                   hit;
	logic [FRAME_W-1:0]     cand;
	logic [FRAME_W-1:0]     rdata;
	logic                   ram_we;

	assign pop       = (state_q == S_IDLE) && cmd_valid && !out_valid_q;
	assign cmd_ready = pop;

	// search begins one past the last frame handed out
	assign start = (next_q == FRAME_W'(FRAME_COUNT - 1)) ? '0 : next_q + 1'b1;

	// frame zero is never free
	assign free_vec = ~in_use_q & ~FRAME_COUNT'(1);
	assign chunk    = free_vec[cidx_q * CHUNK_W +: CHUNK_W];
	assign chunk_m  = (step_q == '0) ? (chunk & ({CHUNK_W{1'b1}} << start_lo_q)) : chunk;
	assign hit      = |chunk_m;

	always_comb begin
		off = '0;
		for (int i = CHUNK_W - 1; i >= 0; i--) begin
			if (chunk_m[i]) begin
				off = OFF_W'(i);
			end
		end
	end

	assign cand   = {cidx_q, off};
	assign ram_we = (state_q == S_SEARCH) && hit;

	ptfa_ram #(
		.WIDTH (FRAME_W),
		.DEPTH (PAGE_COUNT)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (page_q),
		.wdata (cand),
		.raddr (cmd.page),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			in_use_q     <= '0;
			pvalid_q     <= '0;
			next_q       <= '0;
			kind_q       <= K_RANGE;
			page_q       <= '0;
			old_valid_q  <= 1'b0;
			old_frame_q  <= '0;
			cidx_q       <= '0;
			start_lo_q   <= '0;
			step_q       <= '0;
			out_valid_q  <= 1'b0;
			status_q     <= ST_MAPPED;
			frame_addr_q <= '0;
			log_q        <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						kind_q      <= cmd.kind;
						page_q      <= cmd.page;
						old_valid_q <= pvalid_q[cmd.page];
						cidx_q      <= start[FRAME_W-1:OFF_W];
						start_lo_q  <= start[OFF_W-1:0];
						step_q      <= '0;
						if (cmd.kind == K_GUARD || cmd.kind == K_RANGE) begin
							out_valid_q  <= 1'b1;
							status_q     <= (cmd.kind == K_GUARD) ? ST_GUARD : ST_RANGE;
							frame_addr_q <= '0;
							log_q        <= '0;
						end else begin
							state_q <= S_READ;
						end
					end
				end
				S_READ: begin
					if (kind_q == K_UNMAP) begin
						if (old_valid_q && rdata != '0) begin
							in_use_q[rdata] <= 1'b0;
						end
						pvalid_q[page_q] <= 1'b0;
						out_valid_q      <= 1'b1;
						status_q         <= ST_UNMAPPED;
						frame_addr_q     <= '0;
						log_q            <= ADDR_W'({page_q, {PAGE_SHIFT{1'b0}}});
						state_q          <= S_IDLE;
					end else begin
						old_frame_q <= old_valid_q ? rdata : '0;
						state_q     <= S_SEARCH;
					end
				end
				S_SEARCH: begin
					if (hit) begin
						// old frame is in use, so it never equals the new one
						in_use_q[cand] <= 1'b1;
						if (old_frame_q != '0) begin
							in_use_q[old_frame_q] <= 1'b0;
						end
						next_q           <= cand;
						pvalid_q[page_q] <= 1'b1;
						out_valid_q      <= 1'b1;
						status_q         <= ST_MAPPED;
						frame_addr_q     <= ADDR_W'({cand, {PAGE_SHIFT{1'b0}}});
						log_q            <= '0;
						state_q          <= S_IDLE;
					end else if (step_q == STEP_W'(N_CHUNKS)) begin
						out_valid_q  <= 1'b1;
						status_q     <= ST_OOM;
						frame_addr_q <= '0;
						log_q        <= '0;
						state_q      <= S_IDLE;
					end else begin
						cidx_q <= cidx_q + 1'b1;
						step_q <= step_q + 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign frame_addr = frame_addr_q;
	assign log_vaddr  = log_q;

endmodule

`default_nettype wire

### hw/rtl/page_table_frame_allocator_unit.sv
//  channel  direction  handshake            payload
//  request  in         in_valid / in_ready  action, vaddr, page_index
//  result   out        out_valid/out_ready  status, frame_addr, log_vaddr
//
//  front classifies a request and registers it, a two-entry queue feeds the back
//  back starts a request only in idle and once its output register is empty; a reject is
//  answered from idle, an unmap after the table read, a map after the table read and the
//  free-frame scan that walks the bitmap 32 frames per cycle
//  arst_n clears the page valid bits, in-use bitmap, pointer and handshake state
//  a stalled result holds in the output register while the front keeps filling the queue
`timescale 1ns / 1ps
`default_nettype none

module page_table_frame_allocator_unit import ptfa_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// request channel
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [ACT_W-1:0]    action,
	input  wire logic [ADDR_W-1:0]   vaddr,
	input  wire logic [PIDX_W-1:0]   page_index,
	// result channel
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [STATUS_W-1:0]      status,
	output logic [ADDR_W-1:0]        frame_addr,
	output logic [ADDR_W-1:0]        log_vaddr
);

	// classified command from the front stage
	cmd_t fr_cmd;
	logic fr_valid;
	logic fr_ready;

	// head of the command queue
	cmd_t q_cmd;
	logic q_valid;
	logic q_ready;

	// front: decode the action, split the page out of the address, flag
	// guard page and out-of-range requests
	ptfa_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.vaddr        (vaddr),
		.page_index   (page_index),
		.cmd_s1       (fr_cmd),
		.cmd_valid_s1 (fr_valid),
		.cmd_ready    (fr_ready)
	);

	// decouples the front from the variable-length back
	ptfa_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_cmd   (fr_cmd),
		.wr_valid (fr_valid),
		.wr_ready (fr_ready),
		.rd_cmd   (q_cmd),
		.rd_valid (q_valid),
		.rd_ready (q_ready)
	);

	// back: table read-modify-write, next-fit scan, result register
	ptfa_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (q_cmd),
		.cmd_valid  (q_valid),
		.cmd_ready  (q_ready),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.frame_addr (frame_addr),
		.log_vaddr  (log_vaddr)
	);

endmodule

`default_nettype wire

### hw/rtl/ptfa_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module ptfa_checker import ptfa_pkg::*; (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_valid,
	input wire logic                in_ready,
	input wire logic [ACT_W-1:0]    action,
	input wire logic [ADDR_W-1:0]   vaddr,
	input wire logic [PIDX_W-1:0]   page_index,
	input wire logic                out_valid,
	input wire logic                out_ready,
	input wire logic [STATUS_W-1:0] status,
	input wire logic [ADDR_W-1:0]   frame_addr,
	input wire logic [ADDR_W-1:0]   log_vaddr
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status)
			&& $stable(frame_addr) && $stable(log_vaddr))
		else $error("result changed while stalled");

	// a mapped frame is page aligned and never frame zero
	a_map_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_MAPPED |->
			frame_addr[PAGE_SHIFT-1:0] == '0 && frame_addr != '0)
		else $error("bad mapped frame address");

	a_frame_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_MAPPED |-> frame_addr == '0)
		else $error("frame address on a non-map result");

	a_log_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_UNMAPPED |-> log_vaddr == '0)
		else $error("log address on a non-unmap result");

endmodule

bind page_table_frame_allocator_unit ptfa_checker u_ptfa_checker (.*);

`default_nettype wire
